// ----- src/macpu_pkg.sv -----
`default_nettype none

package macpu_pkg;

  localparam int unsigned RamDepth  = 256;
  localparam int unsigned CtrlDepth = 32;
  localparam int unsigned MapDepth  = 16;

  localparam int unsigned RamAw  = $clog2(RamDepth);
  localparam int unsigned CtrlAw = $clog2(CtrlDepth);
  localparam int unsigned MapAw  = $clog2(MapDepth);

  localparam int unsigned WordW = 12;
  localparam int unsigned AddrW = 8;
  localparam int unsigned UpcW  = 5;
  localparam int unsigned CwW   = 24;
  localparam int unsigned OpW   = 2;

  localparam int unsigned BitIp  = 23;
  localparam int unsigned BitLp  = 22;
  localparam int unsigned BitEp  = 21;
  localparam int unsigned BitLm  = 20;
  localparam int unsigned BitR   = 19;
  localparam int unsigned BitW   = 18;
  localparam int unsigned BitLd  = 17;
  localparam int unsigned BitEd  = 16;
  localparam int unsigned BitLi  = 15;
  localparam int unsigned BitEi  = 14;
  localparam int unsigned BitLa  = 13;
  localparam int unsigned BitEa  = 12;
  localparam int unsigned BitA   = 11;
  localparam int unsigned BitS   = 10;
  localparam int unsigned BitEu  = 9;
  localparam int unsigned BitLb  = 8;
  localparam int unsigned BitCd  = 7;
  localparam int unsigned BitMap = 6;
  localparam int unsigned BitHlt = 5;

  typedef enum logic [OpW-1:0] {
    OP_TICK      = 2'd0,
    OP_LOAD_RAM  = 2'd1,
    OP_LOAD_CTRL = 2'd2,
    OP_LOAD_MAP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [AddrW-1:0] index;
    logic [CwW-1:0]   data;
  } in_t;

  typedef struct packed {
    logic [UpcW-1:0]  micro_addr;
    logic [AddrW-1:0] pc_value;
    logic [AddrW-1:0] mar_value;
    logic [WordW-1:0] mdr_value;
    logic [WordW-1:0] acc_value;
    logic [WordW-1:0] alu_value;
    logic [WordW-1:0] b_value;
    logic [WordW-1:0] ir_value;
    logic [WordW-1:0] bus_value;
    logic             halted;
  } out_t;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [RamAw-1:0] addr;
    logic [WordW-1:0] wdata;
  } ram_req_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [CtrlAw-1:0] addr;
    logic [CwW-1:0]    wdata;
  } cs_req_t;

  typedef struct packed {
    logic             we;
    logic [MapAw-1:0] waddr;
    logic [UpcW-1:0]  wdata;
  } map_req_t;

endpackage

`default_nettype wire

// ----- src/macpu_ram.sv -----
`default_nettype none

module macpu_ram (
  input  wire logic               clk_i,
  input  wire macpu_pkg::ram_req_t req_i,
  output logic [macpu_pkg::WordW-1:0] rdata_o
);

  logic [macpu_pkg::WordW-1:0] mem [macpu_pkg::RamDepth];
  logic [macpu_pkg::WordW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/macpu_cstore.sv -----
`default_nettype none

module macpu_cstore (
  input  wire logic              clk_i,
  input  wire macpu_pkg::cs_req_t req_i,
  output logic [macpu_pkg::CwW-1:0] rdata_o
);

  logic [macpu_pkg::CwW-1:0] mem [macpu_pkg::CtrlDepth];
  logic [macpu_pkg::CwW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/macpu_map.sv -----
`default_nettype none

module macpu_map (
  input  wire logic                          clk_i,
  input  wire macpu_pkg::map_req_t            req_i,
  input  wire logic [macpu_pkg::MapAw-1:0]    raddr_i,
  output logic [macpu_pkg::UpcW-1:0]          rdata_o
);

  logic [macpu_pkg::UpcW-1:0] slot_q [macpu_pkg::MapDepth];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      slot_q[req_i.waddr] <= req_i.wdata;
    end
  end

  assign rdata_o = slot_q[raddr_i];

endmodule

`default_nettype wire

// ----- src/microcoded_accumulator_cpu_step_unit.sv -----
// Microprogrammed accumulator machine, one item per input transaction.
// Input channel (in_valid_i/in_ready_o/in_data_i): op 0 runs one
// microinstruction, ops 1..3 load a RAM word, a control word or a map slot.
// Output channel (out_valid_o/out_ready_i/out_data_o): one transaction per
// item carrying the machine registers, micro counter and halt flag after it.
// The accepting cycle reads the control store at the micro counter, the next
// cycle drives the bus, loads the registers and reads or writes main memory
// at the new mar, and the done state then takes the RAM data, looks up the
// map table and updates the micro counter once the output register is free.
// No new item is taken during execute; the next one can be accepted in the
// done state, and its control store read uses the forwarded micro counter.
// A new item is taken while a finished result still waits in the output
// register; when the receiver stalls and a second result is done, the unit
// holds in its final cycle until the output register frees.
// Reset clears all machine registers, the micro counter and the halt flag;
// the memories hold no defined contents until loaded.
`default_nettype none

module microcoded_accumulator_cpu_step_unit (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire macpu_pkg::in_t   in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output macpu_pkg::out_t       out_data_o
);

  localparam int unsigned WordW = macpu_pkg::WordW;
  localparam int unsigned AddrW = macpu_pkg::AddrW;
  localparam int unsigned UpcW  = macpu_pkg::UpcW;
  localparam int unsigned CwW   = macpu_pkg::CwW;

  macpu_pkg::state_e state_q, state_d;
  macpu_pkg::in_t    item_q;
  macpu_pkg::out_t   out_q;
  logic              out_valid_q;

  logic [AddrW-1:0] pc_q, mar_q;
  logic [WordW-1:0] mdr_q, acc_q, alu_q, b_q, ir_q, bus_q;
  logic [UpcW-1:0]  mc_q;
  logic             halt_q;

  logic             cw_ok_q;
  logic             act_q, rd_pend_q, rd_ok_q, map_sel_q, hlt_q;
  logic [UpcW-1:0]  next_q;

  logic out_free, accept, exec_en, done_en;

  macpu_pkg::ram_req_t ram_req;
  macpu_pkg::cs_req_t  cs_req;
  macpu_pkg::map_req_t map_req;
  logic [WordW-1:0]    ram_rdata;
  logic [CwW-1:0]      cs_rdata;
  logic [UpcW-1:0]     map_rdata;

  logic [CwW-1:0]   word;
  logic             active;
  logic [WordW-1:0] bus_n, mdr_l, ir_n, acc_n, b_n, alu_n;
  logic [AddrW-1:0] pc_l, pc_n, mar_n;
  logic             mar_ok;
  logic [UpcW-1:0]  cs_raddr;

  logic [WordW-1:0] mdr_fin;
  logic [UpcW-1:0]  mc_fin;
  logic             halt_fin;

  macpu_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  macpu_cstore u_cstore (
    .clk_i   (clk_i),
    .req_i   (cs_req),
    .rdata_o (cs_rdata)
  );

  macpu_map u_map (
    .clk_i   (clk_i),
    .req_i   (map_req),
    .raddr_i (mdr_fin[WordW-1 -: macpu_pkg::MapAw]),
    .rdata_o (map_rdata)
  );

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      macpu_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = macpu_pkg::ST_EXEC;
      end
      macpu_pkg::ST_EXEC: begin
        state_d = macpu_pkg::ST_DONE;
      end
      macpu_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = in_valid_i ? macpu_pkg::ST_EXEC : macpu_pkg::ST_IDLE;
        end
      end
      default: state_d = macpu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    exec_en    = 1'b0;
    done_en    = 1'b0;
    unique case (state_q)
      macpu_pkg::ST_IDLE: in_ready_o = 1'b1;
      macpu_pkg::ST_EXEC: exec_en = 1'b1;
      macpu_pkg::ST_DONE: begin
        in_ready_o = out_free;
        done_en    = out_free;
      end
      default: ;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  // Microinstruction execute
  always_comb begin
    word   = cw_ok_q ? cs_rdata : '0;
    active = (item_q.op == macpu_pkg::OP_TICK) && !halt_q;

    bus_n = bus_q;
    if (word[macpu_pkg::BitEp]) bus_n = WordW'(pc_q);
    if (word[macpu_pkg::BitEd]) bus_n = mdr_q;
    if (word[macpu_pkg::BitEi]) bus_n = ir_q;
    if (word[macpu_pkg::BitEa]) bus_n = acc_q;
    if (word[macpu_pkg::BitEu]) bus_n = alu_q;

    pc_l  = word[macpu_pkg::BitLp] ? bus_n[AddrW-1:0] : pc_q;
    mar_n = word[macpu_pkg::BitLm] ? bus_n[AddrW-1:0] : mar_q;
    mdr_l = word[macpu_pkg::BitLd] ? bus_n : mdr_q;
    ir_n  = word[macpu_pkg::BitLi] ? bus_n : ir_q;
    acc_n = word[macpu_pkg::BitLa] ? bus_n : acc_q;
    b_n   = word[macpu_pkg::BitLb] ? bus_n : b_q;

    priority if (word[macpu_pkg::BitS]) alu_n = acc_n - b_n;
    else if (word[macpu_pkg::BitA])     alu_n = acc_n + b_n;
    else                                alu_n = alu_q;

    pc_n   = word[macpu_pkg::BitIp] ? pc_l + AddrW'(1) : pc_l;
    mar_ok = {1'b0, mar_n} < (AddrW+1)'(macpu_pkg::RamDepth);
  end

  always_comb begin
    ram_req = '0;
    if (exec_en) begin
      if (item_q.op == macpu_pkg::OP_LOAD_RAM) begin
        ram_req.we    = {1'b0, item_q.index} < (AddrW+1)'(macpu_pkg::RamDepth);
        ram_req.addr  = item_q.index[macpu_pkg::RamAw-1:0];
        ram_req.wdata = item_q.data[WordW-1:0];
      end else begin
        ram_req.re    = active && word[macpu_pkg::BitR] && mar_ok;
        ram_req.we    = active && word[macpu_pkg::BitW] && !word[macpu_pkg::BitR] && mar_ok;
        ram_req.addr  = mar_n[macpu_pkg::RamAw-1:0];
        ram_req.wdata = mdr_l;
      end
    end
  end

  assign cs_raddr = (state_q == macpu_pkg::ST_DONE) ? mc_fin : mc_q;

  always_comb begin
    cs_req = '0;
    if (exec_en) begin
      cs_req.we    = (item_q.op == macpu_pkg::OP_LOAD_CTRL) &&
                     ({1'b0, item_q.index} < (AddrW+1)'(macpu_pkg::CtrlDepth));
      cs_req.addr  = item_q.index[macpu_pkg::CtrlAw-1:0];
      cs_req.wdata = item_q.data;
    end else begin
      cs_req.re   = accept;
      cs_req.addr = cs_raddr[macpu_pkg::CtrlAw-1:0];
    end
  end

  always_comb begin
    map_req       = '0;
    map_req.we    = exec_en && (item_q.op == macpu_pkg::OP_LOAD_MAP) &&
                    ({1'b0, item_q.index} < (AddrW+1)'(macpu_pkg::MapDepth));
    map_req.waddr = item_q.index[macpu_pkg::MapAw-1:0];
    map_req.wdata = item_q.data[UpcW-1:0];
  end

  // Writeback values
  always_comb begin
    mdr_fin  = rd_pend_q ? (rd_ok_q ? ram_rdata : '0) : mdr_q;
    mc_fin   = act_q ? (map_sel_q ? map_rdata : next_q) : mc_q;
    halt_fin = halt_q || hlt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= macpu_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      pc_q        <= '0;
      mar_q       <= '0;
      mdr_q       <= '0;
      acc_q       <= '0;
      alu_q       <= '0;
      b_q         <= '0;
      ir_q        <= '0;
      bus_q       <= '0;
      mc_q        <= '0;
      halt_q      <= 1'b0;
      act_q       <= 1'b0;
      rd_pend_q   <= 1'b0;
      map_sel_q   <= 1'b0;
      hlt_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec_en) begin
        act_q     <= active;
        rd_pend_q <= active && word[macpu_pkg::BitR];
        map_sel_q <= active && word[macpu_pkg::BitMap] && !word[macpu_pkg::BitCd];
        hlt_q     <= active && word[macpu_pkg::BitHlt];
        if (active) begin
          pc_q  <= pc_n;
          mar_q <= mar_n;
          mdr_q <= mdr_l;
          acc_q <= acc_n;
          alu_q <= alu_n;
          b_q   <= b_n;
          ir_q  <= ir_n;
          bus_q <= bus_n;
        end
      end
      if (done_en) begin
        mdr_q       <= mdr_fin;
        mc_q        <= mc_fin;
        halt_q      <= halt_fin;
        act_q       <= 1'b0;
        rd_pend_q   <= 1'b0;
        hlt_q       <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q  <= in_data_i;
      cw_ok_q <= {1'b0, cs_raddr} < (UpcW+1)'(macpu_pkg::CtrlDepth);
    end
    if (exec_en) begin
      rd_ok_q <= mar_ok;
      next_q  <= word[UpcW-1:0];
    end
    if (done_en) begin
      out_q.micro_addr <= mc_fin;
      out_q.pc_value   <= pc_q;
      out_q.mar_value  <= mar_q;
      out_q.mdr_value  <= mdr_fin;
      out_q.acc_value  <= acc_q;
      out_q.alu_value  <= alu_q;
      out_q.b_value    <= b_q;
      out_q.ir_value   <= ir_q;
      out_q.bus_value  <= bus_q;
      out_q.halted     <= halt_fin;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- tb/microcoded_accumulator_cpu_step_unit_tb.sv -----
module microcoded_accumulator_cpu_step_unit_tb;
  import macpu_pkg::*;

  localparam logic [CwW-1:0] C_IP  = 24'd1 << BitIp;
  localparam logic [CwW-1:0] C_LP  = 24'd1 << BitLp;
  localparam logic [CwW-1:0] C_EP  = 24'd1 << BitEp;
  localparam logic [CwW-1:0] C_LM  = 24'd1 << BitLm;
  localparam logic [CwW-1:0] C_R   = 24'd1 << BitR;
  localparam logic [CwW-1:0] C_W   = 24'd1 << BitW;
  localparam logic [CwW-1:0] C_LD  = 24'd1 << BitLd;
  localparam logic [CwW-1:0] C_ED  = 24'd1 << BitEd;
  localparam logic [CwW-1:0] C_LI  = 24'd1 << BitLi;
  localparam logic [CwW-1:0] C_EI  = 24'd1 << BitEi;
  localparam logic [CwW-1:0] C_LA  = 24'd1 << BitLa;
  localparam logic [CwW-1:0] C_EA  = 24'd1 << BitEa;
  localparam logic [CwW-1:0] C_A   = 24'd1 << BitA;
  localparam logic [CwW-1:0] C_S   = 24'd1 << BitS;
  localparam logic [CwW-1:0] C_EU  = 24'd1 << BitEu;
  localparam logic [CwW-1:0] C_LB  = 24'd1 << BitLb;
  localparam logic [CwW-1:0] C_CD  = 24'd1 << BitCd;
  localparam logic [CwW-1:0] C_MAP = 24'd1 << BitMap;
  localparam logic [CwW-1:0] C_HLT = 24'd1 << BitHlt;

  // micro routine entry points of the sample machine
  localparam int UA_FETCH = 0;
  localparam int UA_LDA   = 3;
  localparam int UA_ADD   = 6;
  localparam int UA_SUB   = 11;
  localparam int UA_STA   = 16;
  localparam int UA_JMP   = 19;
  localparam int UA_DBL   = 21;
  localparam int UA_SKIP  = 24;
  localparam int UA_NOP   = 25;

  // opcodes in mdr[11:8] of the sample machine
  localparam int OPC_LDA  = 1;
  localparam int OPC_ADD  = 2;
  localparam int OPC_SUB  = 3;
  localparam int OPC_STA  = 4;
  localparam int OPC_JMP  = 5;
  localparam int OPC_DBL  = 6;
  localparam int OPC_SKIP = 7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  in_t  in_data = '0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  logic [WordW-1:0] ram_image [RamDepth];
  logic [CwW-1:0]   ucode_image [CtrlDepth];
  logic [UpcW-1:0]  map_image [MapDepth];
  out_t             machine = '0;
  out_t             expected_states [$];

  bit sender_idle = 1'b0;
  bit receiver_stall = 1'b0;
  int burst_left = 0;
  int hold_request = 0;
  int fail_count = 0;
  int tick_count = 0;
  int load_count = 0;
  int result_count = 0;
  bit halt_reached = 1'b0;

  microcoded_accumulator_cpu_step_unit DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #2 clk = ~clk;

  function automatic out_t micro_step(input out_t s);
    logic [CwW-1:0] w;
    if (s.halted) return s;
    w = ucode_image[s.micro_addr];
    if (w[BitEp]) s.bus_value = {4'b0, s.pc_value};
    if (w[BitEd]) s.bus_value = s.mdr_value;
    if (w[BitEi]) s.bus_value = s.ir_value;
    if (w[BitEa]) s.bus_value = s.acc_value;
    if (w[BitEu]) s.bus_value = s.alu_value;
    if (w[BitLp]) s.pc_value = s.bus_value[AddrW-1:0];
    if (w[BitLm]) s.mar_value = s.bus_value[AddrW-1:0];
    if (w[BitLd]) s.mdr_value = s.bus_value;
    if (w[BitLi]) s.ir_value = s.bus_value;
    if (w[BitLa]) s.acc_value = s.bus_value;
    if (w[BitLb]) s.b_value = s.bus_value;
    if (w[BitR]) s.mdr_value = ram_image[s.mar_value];
    if (w[BitW]) ram_image[s.mar_value] = s.mdr_value;
    if (w[BitA]) s.alu_value = s.acc_value + s.b_value;
    if (w[BitS]) s.alu_value = s.acc_value - s.b_value;
    if (w[BitIp]) s.pc_value = s.pc_value + 8'd1;
    if (w[BitMap] && !w[BitCd]) s.micro_addr = map_image[s.mdr_value[11:8]];
    else s.micro_addr = w[UpcW-1:0];
    if (w[BitHlt]) s.halted = 1'b1;
    return s;
  endfunction

  function automatic void apply_item(input in_t item);
    case (item.op)
      OP_TICK: begin
        machine = micro_step(machine);
        tick_count++;
      end
      OP_LOAD_RAM: begin
        ram_image[item.index] = item.data[WordW-1:0];
        load_count++;
      end
      OP_LOAD_CTRL: begin
        if (item.index < CtrlDepth) ucode_image[item.index[CtrlAw-1:0]] = item.data;
        load_count++;
      end
      default: begin
        if (item.index < MapDepth) map_image[item.index[MapAw-1:0]] = item.data[UpcW-1:0];
        load_count++;
      end
    endcase
    expected_states.push_back(machine);
  endfunction

  function automatic int unsigned ucode_word(input int a);
    case (a)
      UA_FETCH:     return C_EP | C_LM | (UA_FETCH + 1);
      UA_FETCH + 1: return C_R | C_IP | (UA_FETCH + 2);
      UA_FETCH + 2: return C_ED | C_LI | C_MAP;
      UA_LDA:       return C_EI | C_LM | (UA_LDA + 1);
      UA_LDA + 1:   return C_R | (UA_LDA + 2);
      UA_LDA + 2:   return C_ED | C_LA | UA_FETCH;
      UA_ADD:       return C_EI | C_LM | (UA_ADD + 1);
      UA_ADD + 1:   return C_R | (UA_ADD + 2);
      UA_ADD + 2:   return C_ED | C_LB | (UA_ADD + 3);
      UA_ADD + 3:   return C_A | (UA_ADD + 4);
      UA_ADD + 4:   return C_EU | C_LA | UA_FETCH;
      UA_SUB:       return C_EI | C_LM | (UA_SUB + 1);
      UA_SUB + 1:   return C_R | (UA_SUB + 2);
      UA_SUB + 2:   return C_ED | C_LB | (UA_SUB + 3);
      UA_SUB + 3:   return C_S | (UA_SUB + 4);
      UA_SUB + 4:   return C_EU | C_LA | UA_FETCH;
      UA_STA:       return C_EI | C_LM | (UA_STA + 1);
      UA_STA + 1:   return C_EA | C_LD | (UA_STA + 2);
      UA_STA + 2:   return C_W | UA_FETCH;
      UA_JMP:       return C_EI | C_LP | UA_FETCH;
      UA_DBL:       return C_EA | C_LB | (UA_DBL + 1);
      UA_DBL + 1:   return C_A | (UA_DBL + 2);
      UA_DBL + 2:   return C_EU | C_LA | UA_FETCH;
      UA_SKIP:      return C_MAP | C_CD | C_IP | UA_FETCH;
      default:      return UA_FETCH;
    endcase
  endfunction

  function automatic int unsigned map_word(input int opc);
    case (opc)
      OPC_LDA:  return UA_LDA;
      OPC_ADD:  return UA_ADD;
      OPC_SUB:  return UA_SUB;
      OPC_STA:  return UA_STA;
      OPC_JMP:  return UA_JMP;
      OPC_DBL:  return UA_DBL;
      OPC_SKIP: return UA_SKIP;
      default:  return UA_NOP;
    endcase
  endfunction

  task automatic send_item(input in_t item);
    int gap;
    if (sender_idle && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    apply_item(item);
  endtask

  task automatic issue_load(input op_e op, input int unsigned idx, input int unsigned dat);
    in_t item;
    item.op = op;
    item.index = idx[AddrW-1:0];
    item.data = dat[CwW-1:0];
    send_item(item);
  endtask

  task automatic issue_tick();
    issue_load(OP_TICK, $urandom_range(0, 255), $urandom_range(0, 32'hffffff));
  endtask

  task automatic run_word(input logic [CwW-1:0] w);
    issue_load(OP_LOAD_CTRL, machine.micro_addr, w);
    issue_tick();
  endtask

  task automatic load_microcode();
    for (int a = 0; a < CtrlDepth; a++) issue_load(OP_LOAD_CTRL, a, ucode_word(a));
    for (int o = 0; o < MapDepth; o++) issue_load(OP_LOAD_MAP, o, map_word(o));
  endtask

  task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      fail_count++;
      $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, exp, act);
    end
  endtask

  task automatic compare_state(input out_t exp, input out_t act);
    check_field("micro_addr", exp.micro_addr, act.micro_addr);
    check_field("pc_value", exp.pc_value, act.pc_value);
    check_field("mar_value", exp.mar_value, act.mar_value);
    check_field("mdr_value", exp.mdr_value, act.mdr_value);
    check_field("acc_value", exp.acc_value, act.acc_value);
    check_field("alu_value", exp.alu_value, act.alu_value);
    check_field("b_value", exp.b_value, act.b_value);
    check_field("ir_value", exp.ir_value, act.ir_value);
    check_field("bus_value", exp.bus_value, act.bus_value);
    check_field("halted", exp.halted, act.halted);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      result_count++;
      if (expected_states.size() == 0) begin
        fail_count++;
        $display("%0t unexpected transaction: expected none, actual %h", $time, out_data);
      end else begin
        compare_state(expected_states.pop_front(), out_data);
      end
    end
  end

  initial begin
    int hold_left;
    int rx_left;
    bit rx_busy;
    hold_left = 0;
    rx_left = 0;
    rx_busy = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!receiver_stall) begin
        out_ready <= 1'b1;
      end else begin
        if (rx_left == 0) begin
          rx_busy = !rx_busy;
          rx_left = rx_busy ? $urandom_range(1, 4) : $urandom_range(1, 9);
        end
        rx_left--;
        out_ready <= !rx_busy;
      end
    end
  end

  task automatic test_load_bounds();
    issue_load(OP_LOAD_CTRL, CtrlDepth, 32'hffffff);
    issue_load(OP_LOAD_MAP, MapDepth, 32'hffffff);
    issue_load(OP_LOAD_CTRL, 255, 0);
    issue_load(OP_LOAD_MAP, 255, 0);
  endtask

  task automatic test_fill_stores();
    load_microcode();
    for (int a = 0; a < RamDepth; a++)
      issue_load(OP_LOAD_RAM, a, (a == 0) ? 0 : (a == RamDepth - 1) ? 32'hffffff : $urandom);
  endtask

  task automatic test_datapath_cases();
    sender_idle = 1'b1;
    receiver_stall = 1'b1;
    run_word('0);
    issue_load(OP_LOAD_RAM, machine.mar_value, 12'hfff);
    run_word(C_R);
    run_word(C_ED | C_LP | C_LA | C_LB);
    run_word(C_IP | C_A);
    run_word(C_EU | C_LB | C_S);
    run_word(C_EU | C_LA | C_A | C_S);
    run_word(C_EP | C_ED | C_EI | C_EA | C_EU | C_LM | C_LI | C_LD | C_R | C_W);
    run_word(C_IP | C_LP | C_EP);
    issue_load(OP_LOAD_RAM, machine.mar_value, 12'hfff);
    issue_load(OP_LOAD_MAP, MapDepth - 1, 32'hffffff);
    run_word(C_R | C_MAP | C_CD | CwW'(UA_ADD));
    run_word(C_MAP);
    run_word(C_EA | C_LD | C_W);
  endtask

  task automatic test_backpressure();
    sender_idle = 1'b0;
    receiver_stall = 1'b0;
    load_microcode();
    hold_request = 150;
    repeat (40) issue_tick();
  endtask

  task automatic test_random_programs();
    int pick;
    for (int round = 0; round < 4; round++) begin
      sender_idle = round[0];
      receiver_stall = round[1];
      load_microcode();
      repeat (250) begin
        pick = $urandom_range(0, 99);
        if (pick < 85)
          issue_tick();
        else if (pick < 94)
          issue_load(OP_LOAD_RAM, $urandom_range(0, 255), $urandom_range(0, 32'hffffff));
        else if (pick < 97)
          issue_load(OP_LOAD_CTRL, $urandom_range(0, 255), $urandom & ~C_HLT);
        else
          issue_load(OP_LOAD_MAP, $urandom_range(0, 255), $urandom_range(0, 32'hffffff));
      end
    end
  endtask

  task automatic test_halt();
    sender_idle = 1'b1;
    receiver_stall = 1'b1;
    run_word(C_HLT | C_IP | C_EP | C_LA | CwW'(UA_SUB));
    repeat (3) issue_tick();
    issue_load(OP_LOAD_RAM, RamDepth - 1, 0);
    issue_load(OP_LOAD_CTRL, machine.micro_addr, ucode_word(UA_FETCH));
    issue_load(OP_LOAD_MAP, 0, map_word(OPC_LDA));
    issue_tick();
    halt_reached = machine.halted;
  endtask

  initial begin
    int guard;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_load_bounds();
    test_fill_stores();
    test_datapath_cases();
    test_backpressure();
    test_random_programs();
    test_halt();
    in_valid <= 1'b0;
    guard = 0;
    while (expected_states.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    if (expected_states.size() != 0) begin
      fail_count++;
      $display("%0t %0d expected transactions never arrived", $time, expected_states.size());
    end
    repeat (8) @(posedge clk);
    $display("tb: %0d ticks and %0d store loads, %0d results compared", tick_count, load_count,
             result_count);
    $display("tb: stall, back-pressure and idle patterns exercised; halt reached: %0d",
             halt_reached);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- sim.f -----
src/macpu_pkg.sv
src/macpu_ram.sv
src/macpu_cstore.sv
src/macpu_map.sv
src/microcoded_accumulator_cpu_step_unit.sv
tb/microcoded_accumulator_cpu_step_unit_tb.sv
